### hdl/q2e_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle converter.
package q2e_pkg;

  localparam int IN_W    = 16;
  localparam int ROLL_W  = 13;
  localparam int PITCH_W = 12;
  localparam int YAW_W   = 13;

  // term width: 2*(a*b + c*d) of Q2.14 inputs
  localparam int TW      = 34;
  // rotator datapath and angle widths
  localparam int CW      = 36;
  localparam int ZW      = 34;
  // root of a value up to 2^56
  localparam int SQ_BITS = 29;
  localparam int RW      = 58;

  localparam int ATAN_LEN = 24;

  localparam logic signed [ZW-1:0] HALF_TURN = 34'sd2147483648;
  localparam logic signed [TW-1:0] Q28_ONE   = 34'sd268435456;

  typedef struct packed {
    logic                 hold;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [RW-1:0]      rem;
    logic [SQ_BITS-1:0] root;
  } sqrt_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_lut(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Load a vector into the rotator: a zero sine part settles the angle at once,
  // a negative cosine part is turned by half a turn first.
  function automatic cordic_t cordic_feed(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x);
    cordic_t c;
    c.hold = 1'b0;
    c.x    = x;
    c.y    = y;
    c.z    = '0;
    if (y == '0) begin
      c.hold = 1'b1;
      c.z    = x[CW-1] ? HALF_TURN : '0;
    end else if (x[CW-1]) begin
      c.z = y[CW-1] ? -HALF_TURN : HALF_TURN;
      c.x = -x;
      c.y = -y;
    end
    return c;
  endfunction

endpackage

### hdl/q2e_cordic_cell.sv
// One vectoring rotation step of the angle chain.
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  q2e_pkg::cordic_t  c_i,
  output q2e_pkg::cordic_t  c_o
);

  localparam logic signed [q2e_pkg::ZW-1:0] ATAN =
    q2e_pkg::ZW'(q2e_pkg::atan_lut(STAGE));

  q2e_pkg::cordic_t c_d, c_q;
  logic signed [q2e_pkg::CW-1:0] dx, dy;

  always_comb begin
    dx  = c_i.y >>> STAGE;
    dy  = c_i.x >>> STAGE;
    c_d = c_i;
    if (!c_i.hold) begin
      if (!c_i.y[q2e_pkg::CW-1] && (c_i.y != '0)) begin
        c_d.x = c_i.x + dx;
        c_d.y = c_i.y - dy;
        c_d.z = c_i.z + ATAN;
      end else begin
        c_d.x = c_i.x - dx;
        c_d.y = c_i.y + dy;
        c_d.z = c_i.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

### hdl/q2e_sqrt_cell.sv
// One result bit of the pipelined integer square root.
module q2e_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  q2e_pkg::sqrt_t  s_i,
  output q2e_pkg::sqrt_t  s_o
);

  q2e_pkg::sqrt_t s_d, s_q;
  logic [q2e_pkg::RW-1:0] trial;

  always_comb begin
    // (root + 2^b)^2 - root^2; root has no bits at or below b yet
    trial = ({{(q2e_pkg::RW-q2e_pkg::SQ_BITS){1'b0}}, s_i.root} << (BIT + 1))
          | (q2e_pkg::RW'(1) << (2 * BIT));
    s_d = s_i;
    if (s_i.rem >= trial) begin
      s_d.rem  = s_i.rem - trial;
      s_d.root = s_i.root | (q2e_pkg::SQ_BITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

### hdl/quaternion_to_euler.sv
// Top level: quaternion in, roll, pitch and yaw out through chains of CORDIC cells.
//
// Input beat: s_axis_tdata carries w, x, y, z (signed Q2.14, 16 bits each).
// Output beat: m_axis_tdata carries roll, pitch and yaw in units of
// 2^-ANGLE_FRAC_BITS degree; m_axis_tuser is set when the pitch sine was
// outside plus or minus one and got clamped.
// One beat is taken per cycle while the output is not stalled. The stages
// are products, term sums, a square, 29 root cells, the
// CORDIC cells, a scaling multiply and the output register. The root chain
// and the rotator chain set the pipeline depth; the other angles wait beside it.
// The whole pipeline advances as one; when the output register holds a
// beat that the receiver does not take, every stage holds and s_axis_tready
// drops. Reset clears only the valid bits, so the block comes up empty.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // roll_deg, pitch_deg, yaw_deg, zero fill
  output logic        m_axis_tuser   // pitch_clamped
);

  localparam int TW   = q2e_pkg::TW;
  localparam int CW   = q2e_pkg::CW;
  localparam int ZW   = q2e_pkg::ZW;
  localparam int SQB  = q2e_pkg::SQ_BITS;
  localparam int RW   = q2e_pkg::RW;
  localparam int UNIT = 360 << ANGLE_FRAC_BITS;
  localparam int UW   = $clog2(UNIT) + 1;
  localparam int PW   = ZW + UW;
  localparam int QW   = PW - 32;
  localparam int LAT  = 5 + SQB + CORDIC_STAGES;

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
    logic                 clamp;
  } side_t;

  logic           en;
  logic           accept;
  logic [LAT-1:0] vld_q, vld_d;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign vld_d         = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, wx_q, yz_q, wy_q, zx_q, wz_q, xy_q;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= qw * qw;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
    end
  end

  // term sums and clamp of the pitch sine
  side_t              terms_d, terms_q;
  logic signed [TW-1:0] t2_raw;

  always_comb begin
    terms_d.t0    = (TW'(wx_q) + TW'(yz_q)) <<< 1;
    t2_raw        = (TW'(wy_q) - TW'(zx_q)) <<< 1;
    terms_d.t3    = (TW'(wz_q) + TW'(xy_q)) <<< 1;
    terms_d.t1    = TW'(ww_q) - TW'(xx_q) - TW'(yy_q) + TW'(zz_q);
    terms_d.t4    = TW'(ww_q) + TW'(xx_q) - TW'(yy_q) - TW'(zz_q);
    terms_d.t2    = t2_raw;
    terms_d.clamp = 1'b0;
    if (t2_raw > q2e_pkg::Q28_ONE) begin
      terms_d.t2    = q2e_pkg::Q28_ONE;
      terms_d.clamp = 1'b1;
    end else if (t2_raw < -q2e_pkg::Q28_ONE) begin
      terms_d.t2    = -q2e_pkg::Q28_ONE;
      terms_d.clamp = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      terms_q <= terms_d;
    end
  end

  // square of the sine
  logic [SQB-1:0]    s_mag;
  logic [2*SQB-1:0]  sq_q;
  side_t             sq_side_q;

  always_comb begin
    s_mag = terms_q.t2[TW-1] ? SQB'(-terms_q.t2) : SQB'(terms_q.t2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q      <= s_mag * s_mag;
      sq_side_q <= terms_q;
    end
  end

  // root chain: cosine = floor(sqrt(2^56 - s^2))
  q2e_pkg::sqrt_t sq_c [SQB+1];
  side_t          side_q [SQB];

  always_comb begin
    sq_c[0].rem  = (RW'(1) << 56) - RW'(sq_q);
    sq_c[0].root = '0;
  end

  for (genvar i = 0; i < SQB; i++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT(SQB - 1 - i)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en),
      .s_i  (sq_c[i]),
      .s_o  (sq_c[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= sq_side_q;
      for (int k = 1; k < SQB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // rotator chains: 0 roll, 1 pitch, 2 yaw
  q2e_pkg::cordic_t cc [3][CORDIC_STAGES+1];
  logic             cl_q [CORDIC_STAGES];
  side_t            sd;

  assign sd = side_q[SQB-1];

  always_comb begin
    cc[0][0] = q2e_pkg::cordic_feed(CW'(sd.t0), CW'(sd.t1));
    cc[1][0] = q2e_pkg::cordic_feed(CW'(sd.t2),
                                    {{(CW-SQB){1'b0}}, sq_c[SQB].root});
    cc[2][0] = q2e_pkg::cordic_feed(CW'(sd.t3), CW'(sd.t4));
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      q2e_cordic_cell #(
        .STAGE(i)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (en),
        .c_i  (cc[a][i]),
        .c_o  (cc[a][i+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_q[0] <= sd.clamp;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
        cl_q[k] <= cl_q[k-1];
      end
    end
  end

  // scale binary angle to degree units
  logic [PW-1:0] prod_q [3];
  logic          neg_q  [3];
  logic          cl_u_q;
  logic [ZW-1:0] mag    [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = cc[a][CORDIC_STAGES].z[ZW-1] ? ZW'(-cc[a][CORDIC_STAGES].z)
                                            : ZW'(cc[a][CORDIC_STAGES].z);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= PW'(mag[a]) * PW'(UNIT);
        neg_q[a]  <= cc[a][CORDIC_STAGES].z[ZW-1];
      end
      cl_u_q <= cl_q[CORDIC_STAGES-1];
    end
  end

  // round half away from zero, restore sign, saturate to the field
  function automatic logic [q2e_pkg::ROLL_W-1:0] to_field(input logic [PW-1:0] p,
                                                          input logic neg,
                                                          input int bits);
    logic [QW-1:0]        q;
    logic signed [QW:0]   v, hi, lo;
    q  = QW'((p + (PW'(1) << 31)) >> 32);
    hi = (QW+1)'((1 << (bits - 1)) - 1);
    lo = -hi - (QW+1)'(1);
    v  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return q2e_pkg::ROLL_W'(v);
  endfunction

  logic [q2e_pkg::ROLL_W-1:0]  roll_q;
  logic [q2e_pkg::PITCH_W-1:0] pitch_q;
  logic [q2e_pkg::YAW_W-1:0]   yaw_q;
  logic                        clamp_q;
  logic [q2e_pkg::ROLL_W-1:0]  pitch_full;

  assign pitch_full = to_field(prod_q[1], neg_q[1], q2e_pkg::PITCH_W);

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= to_field(prod_q[0], neg_q[0], q2e_pkg::ROLL_W);
      pitch_q <= pitch_full[q2e_pkg::PITCH_W-1:0];
      yaw_q   <= q2e_pkg::YAW_W'(to_field(prod_q[2], neg_q[2], q2e_pkg::YAW_W));
      clamp_q <= cl_u_q;
    end
  end

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = {2'b00, yaw_q, pitch_q, roll_q};
  assign m_axis_tuser  = clamp_q;

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty pipeline with nothing accepted gives no result
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) && !accept |=> !m_axis_tvalid)
    else $error("result out of an empty pipeline");

  // the cosine never exceeds one
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3+SQB-1] && sq_c[SQB].root[SQB-1] |-> sq_c[SQB].root[SQB-2:0] == '0)
    else $error("root above one");

endmodule

### tb/tb_quaternion_to_euler.sv
// Testbench for the quaternion to Euler angle converter: directed table, random beats, predictor.
module tb_quaternion_to_euler;

  localparam int STAGES    = 16;
  localparam int FRAC      = 4;
  localparam int N_RANDOM  = 1250;
  localparam int LATENCY   = 34 + STAGES;
  localparam longint LIMIT = 400000;
  localparam longint ONE28 = 64'sd1 << 28;
  localparam longint HALF  = 64'sd2147483648;
  localparam int ROLL_W    = q2e_pkg::ROLL_W;
  localparam int PITCH_W   = q2e_pkg::PITCH_W;
  localparam int YAW_W     = q2e_pkg::YAW_W;

  typedef struct packed {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
    logic                      clamped;
  } euler_t;

  typedef struct {
    logic [15:0] w, x, y, z;
    bit          known;
    euler_t      ang;
  } quat_row_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  euler_t    angles_due[$];
  quat_row_t quat_rows[$];
  int        n_err = 0;
  int        n_angles = 0;
  int        n_clamped = 0;
  longint    cycle = 0;
  bit        rx_stall_mode = 1'b0;

  quaternion_to_euler #(.CORDIC_STAGES(STAGES), .ANGLE_FRAC_BITS(FRAC)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint a, dx, dy;
    a = 0;
    if (y == 0) return (x < 0) ? HALF : 0;
    if (x < 0) begin
      a = (y > 0) ? HALF : -HALF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < q2e_pkg::ATAN_LEN; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; a += longint'(q2e_pkg::atan_lut(i));
      end else begin
        x -= dx; y += dy; a -= longint'(q2e_pkg::atan_lut(i));
      end
    end
    return a;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint bam_to_deg(longint a);
    longint unsigned m, q;
    m = (a < 0) ? -a : a;
    q = (m * (64'd360 << FRAC) + (64'd1 << 31)) >> 32;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -(64'sd1 <<< (bits - 1));
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  function automatic euler_t quat_to_euler(logic [15:0] qw, logic [15:0] qx,
                                           logic [15:0] qy, logic [15:0] qz);
    longint w, x, y, z, sr, cr, sp, sy, cy;
    euler_t e;
    w = longint'($signed(qw)); x = longint'($signed(qx));
    y = longint'($signed(qy)); z = longint'($signed(qz));
    sr = 2 * (w * x + y * z);
    cr = w * w - x * x - y * y + z * z;
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = w * w + x * x - y * y - z * z;
    e.clamped = 1'b0;
    if (sp > ONE28) begin
      sp = ONE28; e.clamped = 1'b1;
    end else if (sp < -ONE28) begin
      sp = -ONE28; e.clamped = 1'b1;
    end
    e.roll  = ROLL_W'(clip(bam_to_deg(vector_angle(sr, cr)), ROLL_W));
    e.pitch = PITCH_W'(clip(bam_to_deg(vector_angle(sp, int_root(ONE28 * ONE28 - sp * sp))),
                            PITCH_W));
    e.yaw   = YAW_W'(clip(bam_to_deg(vector_angle(sy, cy)), YAW_W));
    return e;
  endfunction

  function automatic euler_t ang(int r, int p, int y, bit c);
    euler_t e;
    e.roll = ROLL_W'(r); e.pitch = PITCH_W'(p); e.yaw = YAW_W'(y); e.clamped = c;
    return e;
  endfunction

  task automatic add_row(int w, int x, int y, int z, bit known = 1'b0, euler_t e = '0);
    quat_row_t r;
    r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z); r.known = known; r.ang = e;
    quat_rows.push_back(r);
  endtask

  // random content: mostly components between -1 and +1, some raw noise
  task automatic add_random_row();
    int w, x, y, z;
    if ($urandom_range(0, 3) != 0) begin
      w = $signed($urandom_range(0, 32767)) - 16384;
      x = $signed($urandom_range(0, 32767)) - 16384;
      y = $signed($urandom_range(0, 32767)) - 16384;
      z = $signed($urandom_range(0, 32767)) - 16384;
    end else begin
      w = $urandom; x = $urandom; y = $urandom; z = $urandom;
    end
    if ($urandom_range(0, 15) == 0) x = 0;
    if ($urandom_range(0, 15) == 0) y = 0;
    add_row(w, x, y, z);
  endtask

  task automatic send_quat(quat_row_t r);
    euler_t e;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.z, r.y, r.x, r.w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    e = quat_to_euler(r.w, r.x, r.y, r.z);
    if (r.known && e != r.ang)
      $error("table row disagrees with predictor: table %p, predicted %p", r.ang, e);
    angles_due.push_back(r.known ? r.ang : e);
  endtask

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (cycle % 300 == 0) rx_stall_mode <= ~rx_stall_mode;
      m_axis_tready <= rx_stall_mode ? 1'b1 : (($urandom_range(0, 4) != 0) && (cycle % 7 != 3));
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    euler_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.roll = m_axis_tdata[12:0]; got.pitch = m_axis_tdata[24:13];
      got.yaw = m_axis_tdata[37:25]; got.clamped = m_axis_tuser;
      if (angles_due.size() == 0) begin
        $error("output beat with nothing expected");
        n_err++;
      end else begin
        want = angles_due.pop_front();
        n_angles++;
        if (got.clamped) n_clamped++;
        if (got.roll !== want.roll) begin
          $error("roll_deg: expected %0d, got %0d", want.roll, got.roll); n_err++;
        end
        if (got.pitch !== want.pitch) begin
          $error("pitch_deg: expected %0d, got %0d", want.pitch, got.pitch); n_err++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_deg: expected %0d, got %0d", want.yaw, got.yaw); n_err++;
        end
        if (got.clamped !== want.clamped) begin
          $error("pitch_clamped: expected %0b, got %0b", want.clamped, got.clamped); n_err++;
        end
        if (m_axis_tdata[39:38] !== 2'b00) begin
          $error("zero fill: expected 0, got %0b", m_axis_tdata[39:38]); n_err++;
        end
      end
    end
  end

  initial begin
    int burst, wait_n;
    bit drained;
    drained = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    // directed: identity, zero, half-turn cases, clamps, extremes
    add_row(16384, 0, 0, 0, 1'b1, ang(0, 0, 0, 1'b0));
    add_row(0, 0, 0, 0, 1'b1, ang(0, 0, 0, 1'b0));
    add_row(0, 16384, 0, 0, 1'b1, ang(2880, 0, 0, 1'b0));
    add_row(0, 0, 0, 16384, 1'b1, ang(0, 0, 2880, 1'b0));
    add_row(16384, 0, 16384, 0, 1'b1, ang(0, 1440, 0, 1'b1));
    add_row(16384, 0, -16384, 0, 1'b1, ang(0, -1440, 0, 1'b1));
    add_row(11585, 0, 11585, 0);
    add_row(11585, 11585, 0, 0);
    add_row(11585, -11585, 0, 0);
    add_row(11585, 0, 0, 11585);
    add_row(11585, 0, 0, -11585);
    add_row(-16384, 0, 0, 0);
    add_row(32767, 32767, 32767, 32767);
    add_row(-32768, -32768, -32768, -32768);
    add_row(-32768, 32767, -32768, 32767);
    add_row(32767, -32768, 0, 32767);
    add_row(0, 32767, -32768, 0);
    add_row(8192, 8192, 8192, 8192);
    add_row(8192, -8192, 8192, -8192);
    add_row(1, 0, 0, 0);
    add_row(0, 1, -1, 0);
    add_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    add_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    repeat (N_RANDOM) add_random_row();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (quat_rows.size() > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      while (burst > 0 && quat_rows.size() > 0) begin
        send_quat(quat_rows.pop_front());
        burst--;
      end
      wait_n = $urandom_range(0, 5);
      if (wait_n > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      // drain the pipeline once, mid-run
      if (!drained && quat_rows.size() <= 600) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (angles_due.size() > 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (angles_due.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Converted %0d quaternions (%0d with clamped pitch) under bursty input",
             n_angles, n_clamped);
    $display("and a stalling receiver, with %0d mismatches.", n_err);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
